// ----- hdl/bmf_pkg.sv -----
// Shared types and constants for the 3x3 binary morphology filter.
`default_nettype none
package bmf_pkg;
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 13;
    localparam int QDEPTH         = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_NEIGH  = 3'd1,
        REG_OBJ    = 3'd2,
        REG_WIDTH  = 3'd3,
        REG_HEIGHT = 3'd4
    } t_cfg_idx;

    localparam logic [1:0] MODE_ERODE  = 2'd0;
    localparam logic [1:0] MODE_DILATE = 2'd1;

    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_DRAIN = 1'b1;

    localparam logic [7:0] BG_HIGH = 8'd255;
    localparam logic [7:0] BG_LOW  = 8'd0;

    // Per-request control carried from front to back.
    typedef struct packed {
        logic       emit;
        logic       last;
        logic       top_row;
        logic       left_col;
        logic       obj_bit;
        logic       q_inner;
        logic [1:0] mode;
        logic       nb;
        logic [7:0] obj;
    } t_tok;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;
endpackage
`default_nettype wire

// ----- hdl/bmf_front.sv -----
// Front end: config registers, frame counters, request classification.
`default_nettype none
module bmf_front #(
    parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmf_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bmf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bmf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_req_type,
    input  wire logic [7:0]                      i_pixel_in,
    input  wire bmf_pkg::t_q_stat                i_q_stat,
    output logic                                 o_push,
    output bmf_pkg::t_tok                        o_tok,
    output logic [$clog2(MAX_WIDTH)-1:0]         o_col,
    output logic                                 o_frame_ended
);
    import bmf_pkg::*;

    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(MAX_HEIGHT + 1);
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = HW + 1;
    localparam int LW = $clog2(2 * MAX_WIDTH + 3);

    logic [1:0]    r_mode, r_act_mode;
    logic          r_nb, r_act_nb;
    logic [7:0]    r_obj, r_act_obj;
    logic [10:0]   r_fw;
    logic [12:0]   r_fh;
    logic [WW-1:0] r_act_w;
    logic [HW-1:0] r_act_h;
    logic [CW-1:0] r_in_col, n_in_col, r_out_col, n_out_col;
    logic [RW-1:0] r_in_row, n_in_row;
    logic [HW-1:0] r_out_row, n_out_row;
    logic [LW-1:0] r_lag, n_lag;
    logic          r_ended, n_ended;

    logic          accept, first, is_pix, is_drn, use_new, emit, last;
    logic [WW-1:0] clamp_w, w_cur;
    logic [HW-1:0] clamp_h, h_cur;
    logic [1:0]    mode_cur;
    logic          nb_cur;
    logic [7:0]    obj_cur;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ERODE;
            r_nb   <= 1'b0;
            r_obj  <= 8'd0;
            r_fw   <= 11'd1024;
            r_fh   <= 13'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODE:   r_mode <= i_cfg_data[1:0];
                REG_NEIGH:  r_nb   <= i_cfg_data[0];
                REG_OBJ:    r_obj  <= i_cfg_data[7:0];
                REG_WIDTH:  r_fw   <= i_cfg_data[10:0];
                REG_HEIGHT: r_fh   <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_fw == 11'd0)                    clamp_w = WW'(1);
        else if (32'(r_fw) > 32'(MAX_WIDTH))  clamp_w = WW'(MAX_WIDTH);
        else                                  clamp_w = WW'(r_fw);
        if (r_fh == 13'd0)                    clamp_h = HW'(1);
        else if (32'(r_fh) > 32'(MAX_HEIGHT)) clamp_h = HW'(MAX_HEIGHT);
        else                                  clamp_h = HW'(r_fh);
    end

    assign o_ready       = !i_q_stat.full;
    assign accept        = i_valid && o_ready;
    assign o_frame_ended = r_ended;
    assign first   = (r_in_row == '0) && (r_in_col == '0) && !r_ended;
    assign is_pix  = (i_req_type == REQ_PIXEL) && !r_ended;
    assign is_drn  = (i_req_type == REQ_DRAIN) && r_ended;
    assign use_new = is_pix && first;
    assign w_cur    = use_new ? clamp_w : r_act_w;
    assign h_cur    = use_new ? clamp_h : r_act_h;
    assign mode_cur = use_new ? r_mode  : r_act_mode;
    assign nb_cur   = use_new ? r_nb    : r_act_nb;
    assign obj_cur  = use_new ? r_obj   : r_act_obj;
    assign emit = is_drn || (is_pix && !first && r_lag == '0);
    assign last = emit && (32'(r_out_row) + 32'd1 == 32'(h_cur))
                       && (32'(r_out_col) + 32'd1 == 32'(w_cur));
    assign o_push = accept && (is_pix || is_drn);

    always_comb begin
        o_tok.emit     = emit;
        o_tok.last     = last;
        o_tok.top_row  = (r_out_row == '0);
        o_tok.left_col = (r_out_col == '0);
        o_tok.obj_bit  = is_pix && (i_pixel_in == obj_cur);
        // eroded position trails by one row and one column
        o_tok.q_inner  = (32'(r_in_row) >= 32'd2) && (32'(r_in_col) >= 32'd2)
                         && (32'(r_in_row) < 32'(h_cur));
        o_tok.mode     = mode_cur;
        o_tok.nb       = nb_cur;
        o_tok.obj      = obj_cur;
        o_col          = r_in_col;
    end

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        n_lag     = r_lag;
        n_ended   = r_ended;
        if (o_push) begin
            if (32'(r_in_col) + 32'd1 >= 32'(w_cur)) begin
                n_in_col = '0;
                n_in_row = r_in_row + RW'(1);
                if (is_pix && (32'(r_in_row) + 32'd1 >= 32'(h_cur))) n_ended = 1'b1;
            end else begin
                n_in_col = r_in_col + CW'(1);
            end
            if (use_new) begin
                n_lag = LW'(32'd2 * 32'(clamp_w) + 32'd1);
            end else if (is_pix && r_lag != '0) begin
                n_lag = r_lag - LW'(1);
            end
            if (emit) begin
                if (32'(r_out_col) + 32'd1 >= 32'(w_cur)) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + HW'(1);
                end else begin
                    n_out_col = r_out_col + CW'(1);
                end
            end
            if (last) begin
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
                n_ended   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_mode <= MODE_ERODE;
            r_act_nb   <= 1'b0;
            r_act_obj  <= 8'd0;
            r_act_w    <= WW'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
            r_act_h    <= HW'((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024);
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_lag      <= '0;
            r_ended    <= 1'b0;
        end else begin
            if (o_push && use_new) begin
                r_act_mode <= r_mode;
                r_act_nb   <= r_nb;
                r_act_obj  <= r_obj;
                r_act_w    <= clamp_w;
                r_act_h    <= clamp_h;
            end
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
            r_lag     <= n_lag;
            r_ended   <= n_ended;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/bmf_queue.sv -----
// Small request queue between the front end and the window engine.
`default_nettype none
module bmf_queue #(
    parameter int DW = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [DW-1:0]    i_data,
    input  wire logic             i_pop,
    output logic [DW-1:0]         o_data,
    output bmf_pkg::t_q_stat      o_stat
);
    import bmf_pkg::*;

    localparam int PW = $clog2(QDEPTH);
    localparam int NW = $clog2(QDEPTH + 1);

    logic [DW-1:0] r_mem [QDEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [NW-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == NW'(QDEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_data       = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + PW'(1);
            if (i_pop)  r_rp <= r_rp + PW'(1);
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + NW'(1);
                2'b01:   r_cnt <= r_cnt - NW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hdl/bmf_back.sv -----
// Window engine: input line store, erosion, source line store (eroded or input bits), dilation, output register.
`default_nettype none
module bmf_back #(
    parameter int MAX_WIDTH = bmf_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire bmf_pkg::t_q_stat             i_q_stat,
    input  wire bmf_pkg::t_tok                i_head_tok,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] i_head_col,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [7:0]                        o_pixel_out,
    output logic                              o_last_of_frame
);
    import bmf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    logic [1:0]    r_in_mem [MAX_WIDTH];
    logic [1:0]    r_s_mem  [MAX_WIDTH];

    logic          en;
    logic          r_v1, r_v2, r_v3, r_v4, r_ov;
    t_tok          r_t1, r_t2, r_t3, r_t4;
    logic [CW-1:0] r_c1, r_c2, r_c3;
    logic [1:0]    r_in_rd, r_s_rd;
    logic [2:0]    r_iw0, r_iw1, r_iw2;   // input window rows, bit 0 newest column
    logic [2:0]    r_sw0, r_sw1, r_sw2;   // source window rows
    logic          r_s3;
    logic          er, s_bit, res;
    logic [2:0]    m0, m1, m2;

    assign en    = !r_ov || i_ready;
    assign o_pop = en && !i_q_stat.empty;
    assign o_valid = r_ov;

    // stage 1: input line store read, with bypass of the write in flight
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1 <= i_head_tok;
            r_c1 <= i_head_col;
            if (r_v1 && r_c1 == i_head_col) r_in_rd <= {r_in_rd[0], r_t1.obj_bit};
            else                            r_in_rd <= r_in_mem[i_head_col];
            if (r_v1) r_in_mem[r_c1] <= {r_in_rd[0], r_t1.obj_bit};
        end
    end

    // stage 2: input window shift
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t2 <= r_t1;
            r_c2 <= r_c1;
            if (r_v1) begin
                r_iw0 <= {r_iw0[1:0], r_t1.obj_bit};
                r_iw1 <= {r_iw1[1:0], r_in_rd[0]};
                r_iw2 <= {r_iw2[1:0], r_in_rd[1]};
            end
        end
    end

    always_comb begin
        if (r_t2.nb) er = &{r_iw0, r_iw1, r_iw2};
        else         er = r_iw0[1] & r_iw1[0] & r_iw1[1] & r_iw1[2] & r_iw2[1];
        s_bit = r_t2.q_inner & ((r_t2.mode == MODE_DILATE) ? r_iw1[1] : er);
    end

    // stage 3: source bit, source line store read
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t3 <= r_t2;
            r_c3 <= r_c2;
            r_s3 <= s_bit;
            if (r_v3 && r_c3 == r_c2) r_s_rd <= {r_s_rd[0], r_s3};
            else                      r_s_rd <= r_s_mem[r_c2];
            if (r_v3) r_s_mem[r_c3] <= {r_s_rd[0], r_s3};
        end
    end

    // stage 4: source window shift
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t4 <= r_t3;
            if (r_v3) begin
                r_sw0 <= {r_sw0[1:0], r_s3};
                r_sw1 <= {r_sw1[1:0], r_s_rd[0]};
                r_sw2 <= {r_sw2[1:0], r_s_rd[1]};
            end
        end
    end

    // mask neighbors above the first row and left of the first column, then pick the result by mode
    always_comb begin
        m0 = r_sw0;
        m1 = r_sw1;
        m2 = r_t4.top_row ? 3'b000 : r_sw2;
        if (r_t4.left_col) begin
            m0[2] = 1'b0;
            m1[2] = 1'b0;
            m2[2] = 1'b0;
        end
        if (r_t4.mode == MODE_ERODE) res = m1[1];
        else if (r_t4.nb)            res = |{m0, m1, m2};
        else                         res = m0[1] | m1[0] | m1[1] | m1[2] | m2[1];
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v4 && r_t4.emit) begin
            o_pixel_out     <= res ? r_t4.obj : ((r_t4.obj == 8'd0) ? BG_HIGH : BG_LOW);
            o_last_of_frame <= r_t4.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_ov <= r_v4 && r_t4.emit;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/binary_morphology_3x3_filter_unit.sv -----
// Top level of the 3x3 binary morphology filter.
// Takes one request per clock while o_ready is high and gives one result pixel per
// clock while i_ready is high. Output pixel p of a frame comes out with the request
// that carries pixel p+2W+2; the rest follow one per drain request after the frame's
// last pixel. A request passes the front end in its accept cycle, then a 4-entry
// queue, then a 5-stage window engine with two 1-read 1-write column line stores
// (input bits and dilation sources). Registers are sampled at a frame's first pixel.
`default_nettype none
module binary_morphology_3x3_filter_unit #(
    parameter int MAX_WIDTH  = bmf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmf_pkg::MAX_HEIGHT_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bmf_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bmf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic                            i_req_type,
    input  wire logic [7:0]                      i_pixel_in,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [7:0]                           o_pixel_out,
    output logic                                 o_last_of_frame
);
    import bmf_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int DW = $bits(t_tok) + CW;

    logic          push, pop, frame_ended;
    t_tok          f_tok, h_tok;
    logic [CW-1:0] f_col, h_col;
    logic [DW-1:0] q_head;
    t_q_stat       q_stat;

    bmf_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_req_type(i_req_type), .i_pixel_in(i_pixel_in),
        .i_q_stat(q_stat), .o_push(push), .o_tok(f_tok), .o_col(f_col),
        .o_frame_ended(frame_ended)
    );

    bmf_queue #(.DW(DW)) u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(push), .i_data({f_tok, f_col}),
        .i_pop(pop), .o_data(q_head), .o_stat(q_stat)
    );

    assign h_tok = q_head[DW-1:CW];
    assign h_col = q_head[CW-1:0];

    bmf_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_stat(q_stat), .i_head_tok(h_tok), .i_head_col(h_col),
        .o_pop(pop), .o_valid(o_valid), .i_ready(i_ready),
        .o_pixel_out(o_pixel_out), .o_last_of_frame(o_last_of_frame)
    );

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full) else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty) else $error("pop from empty queue");
    a_drain_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready && i_req_type == REQ_DRAIN && !frame_ended) |-> !push)
        else $error("drain request inside a frame was queued");
`endif
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// Self-checking testbench for the 3x3 binary morphology filter unit.
`timescale 1ns / 1ps
module tb;
    import bmf_pkg::*;

    localparam int HIST_DEPTH = 4 * MAX_WIDTH_DEF + 8;
    localparam logic [1:0] MODE_OPEN = 2'd2;
    localparam int STALL_LIMIT = 20000;

    typedef struct {
        logic       req;
        logic [7:0] pix;
    } t_req;

    typedef struct {
        logic [7:0] pix;
        logic       last;
    } t_pix_out;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic        i_req_type = 1'b0;
    logic [7:0]  i_pixel_in = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_pixel_out;
    logic        o_last_of_frame;

    binary_morphology_3x3_filter_unit u_dut (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .o_ready, .i_req_type, .i_pixel_in,
        .o_valid, .i_ready, .o_pixel_out, .o_last_of_frame
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    t_req     pend_reqs[$];
    t_pix_out want_pixels[$];
    int n_err = 0, n_acc = 0, n_res = 0, n_frames = 0, cycle = 0;
    int n_wait = 0, hold_cnt = 0;
    bit held = 0;

    // register mirrors as written, and the copies sampled at frame start
    logic [1:0]  reg_mode = MODE_ERODE;
    logic        reg_nb = 1'b0;
    logic [7:0]  reg_obj = 8'd0;
    logic [10:0] reg_w = 11'd1024;
    logic [12:0] reg_h = 13'd1024;
    logic [1:0]  f_mode;
    logic        f_nb;
    logic [7:0]  f_obj;
    int f_w, f_h;
    bit obj_hist[HIST_DEPTH];
    int in_row = 0, in_col = 0, out_pos = 0;
    bit draining = 0;

    function automatic int clamp_dim(int v, int maxv);
        return (v < 1) ? 1 : (v > maxv) ? maxv : v;
    endfunction

    function automatic bit interior(int r, int c);
        return r >= 1 && c >= 1 && r + 2 <= f_h && c + 2 <= f_w;
    endfunction

    function automatic bit in_elem(int dr, int dc);
        return f_nb || dr == 0 || dc == 0;
    endfunction

    function automatic bit obj_at(int r, int c);
        return obj_hist[(r * f_w + c) % HIST_DEPTH];
    endfunction

    function automatic bit erode_at(int r, int c);
        if (!interior(r, c)) return 0;
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (in_elem(dr, dc) && !obj_at(r + dr, c + dc)) return 0;
        return 1;
    endfunction

    function automatic bit morph_at(int r, int c);
        if (f_mode == MODE_ERODE) return erode_at(r, c);
        for (int dr = -1; dr <= 1; dr++)
            for (int dc = -1; dc <= 1; dc++)
                if (in_elem(dr, dc) && interior(r + dr, c + dc) &&
                    ((f_mode == MODE_DILATE) ? obj_at(r + dr, c + dc)
                                             : erode_at(r + dr, c + dc)))
                    return 1;
        return 0;
    endfunction

    function automatic void emit_pixel();
        t_pix_out e;
        e.pix  = morph_at(out_pos / f_w, out_pos % f_w) ? f_obj :
                 (f_obj == 8'd0) ? BG_HIGH : BG_LOW;
        e.last = (out_pos + 1 >= f_w * f_h);
        want_pixels.push_back(e);
        out_pos++;
        if (e.last) begin
            in_row = 0; in_col = 0; out_pos = 0; draining = 0;
        end
    endfunction

    function automatic void filter_step(logic req, logic [7:0] pix);
        int idx;
        if (req == REQ_DRAIN) begin
            if (draining) emit_pixel();
            return;
        end
        if (draining) return;
        if (in_row == 0 && in_col == 0) begin
            f_mode = reg_mode; f_nb = reg_nb; f_obj = reg_obj;
            f_w = clamp_dim(reg_w, MAX_WIDTH_DEF);
            f_h = clamp_dim(reg_h, MAX_HEIGHT_DEF);
        end
        idx = in_row * f_w + in_col;
        obj_hist[idx % HIST_DEPTH] = (pix == f_obj);
        if (++in_col >= f_w) begin
            in_col = 0;
            if (++in_row >= f_h) draining = 1;
        end
        if (idx >= 2 * f_w + 2) emit_pixel();
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch #%0d at result %0d: %s got %0d want %0d",
                 n_err, n_res, what, got, want);
        n_err++;
    endtask

    // long no-gap window on both sides
    function automatic bit gap();
        return !(cycle >= 3000 && cycle < 6000) && $urandom_range(99) < 29;
    endfunction

    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                filter_step(i_req_type, i_pixel_in);
                n_acc++;
            end
            if (!i_valid || o_ready) begin
                if (pend_reqs.size() > 0 && !gap()) begin
                    i_valid    <= 1'b1;
                    i_req_type <= pend_reqs[0].req;
                    i_pixel_in <= pend_reqs[0].pix;
                    void'(pend_reqs.pop_front());
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                n_res++;
                if (want_pixels.size() == 0) begin
                    report("unexpected result, pixel", o_pixel_out, -1);
                end else begin
                    if (o_pixel_out !== want_pixels[0].pix)
                        report("pixel_out", o_pixel_out, want_pixels[0].pix);
                    if (o_last_of_frame !== want_pixels[0].last)
                        report("last_of_frame", o_last_of_frame, want_pixels[0].last);
                    void'(want_pixels.pop_front());
                end
            end
            // one long receiver hold-off so the input side backs up
            if (hold_cnt > 0) begin
                hold_cnt <= hold_cnt - 1;
                i_ready  <= 1'b0;
            end else if (!held && n_acc > 800) begin
                held     <= 1'b1;
                hold_cnt <= 300;
                i_ready  <= 1'b0;
            end else begin
                i_ready <= !gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) ||
            (pend_reqs.size() == 0 && !i_valid && want_pixels.size() == 0)) begin
            n_wait <= 0;
        end else if (n_wait >= STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("** binary_morphology_3x3_filter_unit: FAILED **");
            $finish;
        end else begin
            n_wait <= n_wait + 1;
        end
    end

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pend_reqs.size() > 0 || i_valid || want_pixels.size() > 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, int data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data[CFG_DATA_W-1:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            REG_MODE:   reg_mode = data[1:0];
            REG_NEIGH:  reg_nb   = data[0];
            REG_OBJ:    reg_obj  = data[7:0];
            REG_WIDTH:  reg_w    = data[10:0];
            REG_HEIGHT: reg_h    = data[12:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic push_req(logic req, logic [7:0] pix);
        t_req t;
        t.req = req;
        t.pix = pix;
        pend_reqs.push_back(t);
    endtask

    // one frame with the current registers; noise adds ignored requests
    task automatic send_frame(int obj_pct, bit noise);
        int w, h, total, drains;
        w = clamp_dim(reg_w, MAX_WIDTH_DEF);
        h = clamp_dim(reg_h, MAX_HEIGHT_DEF);
        total = w * h;
        drains = (total > 2 * w + 2) ? 2 * w + 2 : total;
        for (int i = 0; i < total; i++) begin
            if (noise && $urandom_range(19) == 0) push_req(REQ_DRAIN, $urandom_range(255));
            push_req(REQ_PIXEL, ($urandom_range(99) < obj_pct) ? reg_obj
                                                              : 8'($urandom_range(255)));
        end
        if (noise) push_req(REQ_PIXEL, $urandom_range(255));
        for (int i = 0; i < drains; i++) begin
            if (noise && $urandom_range(9) == 0) push_req(REQ_PIXEL, $urandom_range(255));
            push_req(REQ_DRAIN, $urandom_range(255));
        end
        n_frames++;
        while (pend_reqs.size() > 64) @(negedge i_clk);
    endtask

    task automatic set_all(int m, int nb, int obj, int w, int h);
        wait_idle();
        write_reg(REG_MODE, m);
        write_reg(REG_NEIGH, nb);
        write_reg(REG_OBJ, obj);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
    endtask

    initial begin
        int m, k;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: stray drain, tiny frames, all-object, every mode and element
        push_req(REQ_DRAIN, 8'hFF);
        set_all(MODE_ERODE, 0, 0, 0, 1);
        send_frame(100, 0);
        set_all(MODE_ERODE, 0, 255, 3, 3);
        send_frame(100, 0);
        set_all(MODE_DILATE, 1, 8'hA5, 3, 3);
        send_frame(50, 0);
        set_all(MODE_OPEN, 0, 0, 2, 2);
        send_frame(100, 0);

        // random frames, a few at the size extremes
        k = 0;
        while (n_acc < 1800 + 3072 + 4096 + 2048) begin
            k++;
            if (k == 1 || $urandom_range(2) == 0) begin
                wait_idle();
                m = $urandom_range(3);
                write_reg(REG_MODE, m);
                write_reg(REG_NEIGH, $urandom_range(1));
                case ($urandom_range(3))
                    0: write_reg(REG_OBJ, 0);
                    1: write_reg(REG_OBJ, 255);
                    default: write_reg(REG_OBJ, $urandom_range(255));
                endcase
                case (k)
                    6:  begin write_reg(REG_WIDTH, 2047); write_reg(REG_HEIGHT, 2); end
                    12: begin write_reg(REG_WIDTH, 1024); write_reg(REG_HEIGHT, 3); end
                    18: begin write_reg(REG_WIDTH, 1); write_reg(REG_HEIGHT, 8191); end
                    24: begin write_reg(REG_WIDTH, 5); write_reg(REG_HEIGHT, 0); end
                    default: begin
                        write_reg(REG_WIDTH, $urandom_range(12, 1));
                        write_reg(REG_HEIGHT, $urandom_range(10, 1));
                    end
                endcase
            end
            if (k == 30) wait_idle();   // sender pause with nothing outstanding
            send_frame($urandom_range(95, 40), $urandom_range(4) == 0);
        end

        wait_idle();
        $display("covered %0d requests, %0d result pixels over %0d frames,", n_acc, n_res,
                 n_frames);
        $display("all modes and elements, size extremes and ignored requests");
        if (n_err == 0) begin
            $display("** binary_morphology_3x3_filter_unit: PASSED **");
        end else begin
            $display("** binary_morphology_3x3_filter_unit: FAILED **");
        end
        $finish;
    end
endmodule
